// ===== rtl/bmx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_pkg
// Shared constants and types for the binary trie maximum-XOR unit.
// ----------------------------------------------------------------------------
package bmx_pkg;

  // Default key width and node pool size.
  localparam int unsigned KEY_BITS_DEF   = 31;
  localparam int unsigned NODE_COUNT_DEF = 8192;

  // Node 0 is the "no child" code, node 1 is the root, allocation starts at 2.
  localparam int unsigned ROOT_NODE  = 1;
  localparam int unsigned FIRST_FREE = 2;

  // Status from the trie walker to the output stage.
  typedef struct packed {
    logic done;
    logic pool_full;
  } bmx_status_t;

endpackage

// ===== rtl/bmx_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_in_if
// Key channel: valid/ready handshake carrying one key per transaction.
// ----------------------------------------------------------------------------
interface bmx_in_if import bmx_pkg::*; #(
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

// ===== rtl/bmx_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_out_if
// Result channel: valid/ready handshake carrying one query result.
// ----------------------------------------------------------------------------
interface bmx_out_if import bmx_pkg::*; #(
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] best_xor;
  logic [KEY_BITS-1:0] running_max;
  logic                pool_full;

  modport source (output valid, output best_xor, output running_max, output pool_full,
                  input ready);
  modport sink   (input valid, input best_xor, input running_max, input pool_full,
                  output ready);
endinterface

// ===== rtl/bmx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bmx_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_walker
// Sequencer that clears the node RAM, then for each key walks the trie once
// to insert it and once more to find the maximum XOR, one level per cycle.
// ----------------------------------------------------------------------------
module bmx_walker import bmx_pkg::*; #(
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF,
  localparam int unsigned NW        = $clog2(NODE_COUNT),
  localparam int unsigned LW        = $clog2(KEY_BITS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                key_valid_i,
  output logic                key_ready_o,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic                take_i,
  output bmx_status_t         status_o,
  output logic [KEY_BITS-1:0] best_xor_o,
  output logic                ram_we_o,
  output logic [NW-1:0]       ram_waddr_o,
  output logic [2*NW-1:0]     ram_wdata_o,
  output logic [NW-1:0]       ram_raddr_o,
  input  logic [2*NW-1:0]     ram_rdata_i
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_INSERT = 5'b00100,
    ST_QUERY  = 5'b01000,
    ST_DONE   = 5'b10000
  } walk_state_e;

  localparam logic [NW-1:0] ROOT       = NW'(ROOT_NODE);
  localparam logic [NW-1:0] LAST_ENTRY = NW'(NODE_COUNT - 1);
  localparam logic [NW:0]   POOL_END   = (NW+1)'(NODE_COUNT);
  localparam logic [LW-1:0] TOP_LEVEL  = LW'(KEY_BITS - 1);

  walk_state_e         state_q, state_d;
  logic [NW-1:0]       clr_q, clr_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [NW-1:0]       node_q, node_d;
  logic [LW-1:0]       level_q, level_d;
  logic [NW:0]         free_q, free_d;
  logic                full_q, full_d;
  logic [KEY_BITS-1:0] result_q, result_d;

  logic [NW-1:0] zero_c, one_c, same_c, other_c, nxt;
  logic          key_bit, go, adv;

  assign zero_c  = ram_rdata_i[NW-1:0];
  assign one_c   = ram_rdata_i[2*NW-1:NW];
  assign key_bit = key_q[level_q];
  assign same_c  = key_bit ? one_c : zero_c;
  assign other_c = key_bit ? zero_c : one_c;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    key_d       = key_q;
    node_d      = node_q;
    level_d     = level_q;
    free_d      = free_q;
    full_d      = full_q;
    result_d    = result_q;
    nxt         = '0;
    go          = 1'b0;
    adv         = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = node_q;
    ram_wdata_o = key_bit ? {free_q[NW-1:0], zero_c} : {one_c, free_q[NW-1:0]};
    ram_raddr_o = ROOT;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + NW'(1);
        if (clr_q == LAST_ENTRY) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // The root read goes out in the accept cycle.
        if (key_valid_i) begin
          key_d   = key_i;
          node_d  = ROOT;
          level_d = TOP_LEVEL;
          full_d  = 1'b0;
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (same_c != '0) begin
          nxt = same_c;
          go  = 1'b1;
        end else if (free_q >= POOL_END) begin
          full_d = 1'b1;
        end else begin
          ram_we_o = 1'b1;
          nxt      = free_q[NW-1:0];
          free_d   = free_q + (NW+1)'(1);
          go       = 1'b1;
        end
        if (go && level_q != '0) begin
          node_d      = nxt;
          level_d     = level_q - LW'(1);
          ram_raddr_o = nxt;
        end else begin
          // Insert finished or stopped on a full pool: start the query at the root.
          node_d   = ROOT;
          level_d  = TOP_LEVEL;
          result_d = '0;
          state_d  = ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (other_c != '0) begin
          node_d            = other_c;
          result_d[level_q] = 1'b1;
          adv               = 1'b1;
        end else if (same_c != '0) begin
          node_d = same_c;
          adv    = 1'b1;
        end
        ram_raddr_o = node_d;
        if (!adv || level_q == '0) begin
          state_d = ST_DONE;
        end else begin
          level_d = level_q - LW'(1);
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      free_q  <= (NW+1)'(FIRST_FREE);
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    node_q   <= node_d;
    level_q  <= level_d;
    result_q <= result_d;
  end

  assign key_ready_o        = (state_q == ST_IDLE);
  assign status_o.done      = (state_q == ST_DONE);
  assign status_o.pool_full = full_q;
  assign best_xor_o         = result_q;

endmodule

// ===== rtl/binary_trie_max_xor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit
// Inserts each key into a binary trie and reports the largest XOR of the key
// with any stored key, together with the running maximum since reset.
// ----------------------------------------------------------------------------
//   Channel | Dir | Payload                              | Handshake
//   in_i    | in  | key                                  | valid / ready
//   out_o   | out | best_xor, running_max, pool_full     | valid / ready
//
// After reset the node RAM is cleared, one entry per cycle; no key is taken
// meanwhile. For each key the insert and the query each walk one trie level
// per read of the node RAM's single read port. A result waits in the output
// register while the next key is walked; the walker stalls at the end of its
// query only if that register is still full.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_unit import bmx_pkg::*; #(
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmx_in_if.sink    in_i,
  bmx_out_if.source out_o
);

  localparam int unsigned NW = $clog2(NODE_COUNT);

  logic                ram_we;
  logic [NW-1:0]       ram_waddr, ram_raddr;
  logic [2*NW-1:0]     ram_wdata, ram_rdata;
  bmx_status_t         walk_status;
  logic [KEY_BITS-1:0] walk_best;
  logic                take;

  logic                out_valid_q, out_valid_d;
  logic [KEY_BITS-1:0] best_q, best_d;
  logic [KEY_BITS-1:0] runmax_q, runmax_d;
  logic                full_q, full_d;

  bmx_ram #(
    .WIDTH (2*NW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bmx_walker #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_valid_i (in_i.valid),
    .key_ready_o (in_i.ready),
    .key_i       (in_i.key),
    .take_i      (take),
    .status_o    (walk_status),
    .best_xor_o  (walk_best),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // The walker hands over its result whenever the output register is free.
  assign take = walk_status.done && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    best_d      = best_q;
    runmax_d    = runmax_q;
    full_d      = full_q;
    if (take) begin
      out_valid_d = 1'b1;
      best_d      = walk_best;
      full_d      = walk_status.pool_full;
      if (walk_best > runmax_q) begin
        runmax_d = walk_best;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      runmax_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      runmax_q    <= runmax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    full_q <= full_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.best_xor    = best_q;
  assign out_o.running_max = runmax_q;
  assign out_o.pool_full   = full_q;

`ifndef SYNTH
  // The running maximum never falls below the result it is shown with.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (runmax_q >= best_q))
    else $error("running maximum below current best_xor");

  // The walker leaves idle on accepting a key, so a key is never taken twice in a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("key channel ready straight after a transaction");

  // A handed-over result lands in the output register unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (out_valid_q && best_q == $past(walk_best)))
    else $error("walker result not captured in output register");
`endif

endmodule

// ===== tb/binary_trie_max_xor_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit_tb
// Streams keys into the trie unit and checks every result against a predictor
// that keeps its own copy of the node memory. A short directed run covers the
// key extremes and duplicates; random keys then fill the node pool until it
// runs out and keep going with reused, near-duplicate and complemented keys.
// Both channels stall at random, with one quiet stretch on each side.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_unit_tb;
  import bmx_pkg::*;

  localparam int unsigned KEY_W       = KEY_BITS_DEF;
  localparam int unsigned NODES       = NODE_COUNT_DEF;
  localparam int unsigned NODE_W      = $clog2(NODES);
  localparam int          RANDOM_KEYS = 1200;
  localparam int          FILL_KEYS   = 400;
  localparam int          IDLE_PCT    = 14;
  localparam int          DRAIN_WAIT  = 200;
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [KEY_W-1:0] best_xor;
    logic [KEY_W-1:0] running_max;
    logic             pool_full;
  } xor_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bmx_in_if  #(.KEY_BITS(KEY_W)) key_bus ();
  bmx_out_if #(.KEY_BITS(KEY_W)) xor_bus ();

  binary_trie_max_xor_unit #(
    .KEY_BITS  (KEY_W),
    .NODE_COUNT(NODES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (key_bus),
    .out_o (xor_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: a private copy of the trie, empty as after reset.
  logic [NODE_W-1:0] zero_child [NODES] = '{default: '0};
  logic [NODE_W-1:0] one_child  [NODES] = '{default: '0};
  logic [NODE_W:0]   free_node = (NODE_W + 1)'(FIRST_FREE);
  logic [KEY_W-1:0]  best_seen = '0;

  logic [KEY_W-1:0] key_q[$];
  xor_result_t      expected_q[$];

  int keys_taken   = 0;
  int results_seen = 0;
  int full_results = 0;
  int errors       = 0;
  int cycles       = 0;

  // Inserts the key, then walks for the largest XOR against what is stored.
  function automatic xor_result_t trie_step(input logic [KEY_W-1:0] key);
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] nxt;
    logic [KEY_W-1:0]  best;
    logic              full;
    logic              stop;
    xor_result_t       res;
    int                lvl;
    node = NODE_W'(ROOT_NODE);
    full = 1'b0;
    stop = 1'b0;
    for (lvl = KEY_W - 1; lvl >= 0; lvl--) begin
      if (!stop) begin
        nxt = key[lvl] ? one_child[node] : zero_child[node];
        if (nxt == '0) begin
          if (free_node >= NODES) begin
            // Out of nodes: the partial path stays in the trie.
            full = 1'b1;
            stop = 1'b1;
          end else begin
            nxt = free_node[NODE_W-1:0];
            free_node = free_node + 1'b1;
            if (key[lvl]) one_child[node] = nxt;
            else zero_child[node] = nxt;
          end
        end
        node = nxt;
      end
    end
    node = NODE_W'(ROOT_NODE);
    best = '0;
    stop = 1'b0;
    for (lvl = KEY_W - 1; lvl >= 0; lvl--) begin
      if (!stop) begin
        nxt = key[lvl] ? zero_child[node] : one_child[node];
        if (nxt != '0) begin
          best[lvl] = 1'b1;
          node = nxt;
        end else begin
          nxt = key[lvl] ? one_child[node] : zero_child[node];
          // A dead end leaves the remaining low bits at zero.
          if (nxt == '0) stop = 1'b1;
          else node = nxt;
        end
      end
    end
    if (best > best_seen) best_seen = best;
    res.best_xor    = best;
    res.running_max = best_seen;
    res.pool_full   = full;
    return res;
  endfunction

  // Key driver: each accepted transaction is predicted on the spot.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bus.valid <= 1'b0;
      key_bus.key   <= '0;
    end else begin
      if (key_bus.valid && key_bus.ready) begin
        expected_q.push_back(trie_step(key_bus.key));
        keys_taken++;
      end
      if (!key_bus.valid || key_bus.ready) begin
        if (key_q.size() != 0 &&
            ((keys_taken >= 500 && keys_taken < 700) || $urandom_range(99) >= IDLE_PCT)) begin
          key_bus.valid <= 1'b1;
          key_bus.key   <= key_q.pop_front();
        end else begin
          key_bus.valid <= 1'b0;
          key_bus.key   <= KEY_W'($urandom());
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_bus.ready <= 1'b0;
    end else begin
      if (xor_bus.valid && xor_bus.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing outstanding: best_xor %h running_max %h full %b",
                   $time, xor_bus.best_xor, xor_bus.running_max, xor_bus.pool_full);
          errors++;
        end else begin
          automatic xor_result_t want = expected_q.pop_front();
          if (xor_bus.best_xor !== want.best_xor) begin
            $display("%0t: best_xor expected %h actual %h", $time, want.best_xor,
                     xor_bus.best_xor);
            errors++;
          end
          if (xor_bus.running_max !== want.running_max) begin
            $display("%0t: running_max expected %h actual %h", $time, want.running_max,
                     xor_bus.running_max);
            errors++;
          end
          if (xor_bus.pool_full !== want.pool_full) begin
            $display("%0t: pool_full expected %b actual %b", $time, want.pool_full,
                     xor_bus.pool_full);
            errors++;
          end
          if (want.pool_full) full_results++;
        end
        results_seen++;
      end
      xor_bus.ready <= (results_seen >= 450 && results_seen < 750) ||
                       ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d keys taken, %0d results seen",
               cycles, keys_taken, results_seen);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] k;
    int               total;
    int               i;

    // Directed keys: growing maximum, duplicates, single bits, extremes.
    key_q.push_back('0);
    key_q.push_back('0);
    key_q.push_back(KEY_W'(1));
    key_q.push_back(KEY_W'(6));
    key_q.push_back(KEY_W'(6));
    key_q.push_back(KEY_W'(1) << 20);
    key_q.push_back((KEY_W'(1) << 20) | KEY_W'(5));
    key_q.push_back(KEY_W'(1) << (KEY_W - 1));
    key_q.push_back(~(KEY_W'(1) << (KEY_W - 1)));
    key_q.push_back('1);
    key_q.push_back(KEY_W'(32'h5555_5555));
    key_q.push_back(KEY_W'(32'h2AAA_AAAA));
    key_q.push_back(~KEY_W'(1));
    key_q.push_back('1);
    key_q.push_back(~(KEY_W'(1) << 15));

    // Fresh keys first so the pool runs dry, then a mix over the full trie.
    for (i = 0; i < RANDOM_KEYS; i++) begin
      k = key_q[$urandom_range(key_q.size() - 1)];
      if (i < FILL_KEYS) begin
        k = KEY_W'($urandom());
      end else begin
        case ($urandom_range(9)) inside
          [0:3]: k = KEY_W'($urandom());
          [4:5]: k = k;
          [6:7]: k = k ^ KEY_W'($urandom_range(255, 1));
          8:     k = ~k;
          default: begin
            k = KEY_W'(1) << $urandom_range(KEY_W - 1);
            if ($urandom_range(1)) k = ~k;
          end
        endcase
      end
      key_q.push_back(k);
    end
    total = key_q.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (keys_taken == total && expected_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d keys sent, %0d results checked in %0d cycles", total, results_seen, cycles);
    $display("%0d nodes allocated, %0d results with the pool exhausted",
             free_node - FIRST_FREE, full_results);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
